// ===== sv/handwheel_jog_controller_unit_macros.svh =====
// assertion macros shared by the handwheel jog controller rtl
`ifndef HANDWHEEL_JOG_CONTROLLER_UNIT_MACROS_SVH
`define HANDWHEEL_JOG_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define HJC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hjc check failed");

// next-cycle implication, disabled while reset is held
`define HJC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hjc check failed");

`endif

// ===== sv/hjc_pkg.sv =====
// types, constants and the quadrature table of the handwheel jog controller
`default_nettype none
package hjc_pkg;

    localparam int DeltaWidth = 16;
    localparam int CountWidth = 23;
    localparam int MultWidth  = 8;
    localparam int CfgIdxWidth = 3;

    localparam logic [2:0] AXIS_NONE   = 3'd4;
    localparam logic       FUNC_SAMPLE = 1'b0;
    localparam logic       FUNC_POLL   = 1'b1;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_MULT_LOW  = 3'd0,
        REG_MULT_MID  = 3'd1,
        REG_MULT_HIGH = 3'd2,
        REG_MOTOR_CNT = 3'd3,
        REG_ENC_PRES  = 3'd4
    } t_reg_idx;

    localparam logic [MultWidth-1:0] RST_MULT_LOW  = 8'd1;
    localparam logic [MultWidth-1:0] RST_MULT_MID  = 8'd10;
    localparam logic [MultWidth-1:0] RST_MULT_HIGH = 8'd100;
    localparam logic [3:0]           RST_MOTOR_CNT = 4'd4;
    localparam logic                 RST_ENC_PRES  = 1'b1;

    localparam logic signed [1:0] QUAD_NONE = 2'sd0;
    localparam logic signed [1:0] QUAD_INC  = 2'sd1;
    localparam logic signed [1:0] QUAD_DEC  = -2'sd1;

    typedef struct packed {
        logic       func;
        logic       enc_a;
        logic       enc_b;
        logic [3:0] axis_lines;
        logic [2:0] mult_lines;
        logic       motion_idle;
        logic       halted;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            axis_sel;
        logic                  pilot;
        logic [MultWidth-1:0]  mult_now;
        logic                  step_dir;
        logic [CountWidth-1:0] step_count;
    } t_out_item;

    typedef struct packed {
        logic [MultWidth-1:0] mult_low;
        logic [MultWidth-1:0] mult_mid;
        logic [MultWidth-1:0] mult_high;
        logic [3:0]           motor_cnt;
        logic                 enc_pres;
    } t_cfg;

    // transition table indexed by {previous ab, current ab}
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = QUAD_DEC;
            4'd2, 4'd4, 4'd11, 4'd13: d = QUAD_INC;
            default: d = QUAD_NONE;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hjc_quad.sv =====
// quadrature decode and saturating delta accumulate for one sample
`default_nettype none
module hjc_quad (
    input  wire logic [1:0]                     i_prev_ab,
    input  wire logic [1:0]                     i_ab,
    input  wire logic signed [hjc_pkg::DeltaWidth-1:0] i_delta,
    output logic signed [hjc_pkg::DeltaWidth-1:0]      o_delta
);
    import hjc_pkg::*;

    localparam logic signed [DeltaWidth:0] SumMax = (DeltaWidth+1)'(2**(DeltaWidth-1) - 1);
    localparam logic signed [DeltaWidth:0] SumMin = -(DeltaWidth+1)'(2**(DeltaWidth-1));

    logic signed [1:0]          step;
    logic signed [DeltaWidth:0] sum;

    always_comb begin
        step = quad_step({i_prev_ab, i_ab});
        sum  = (DeltaWidth+1)'(i_delta) + (DeltaWidth+1)'(step);
        if (sum > SumMax) begin
            o_delta = SumMax[DeltaWidth-1:0];
        end else if (sum < SumMin) begin
            o_delta = SumMin[DeltaWidth-1:0];
        end else begin
            o_delta = sum[DeltaWidth-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/hjc_poll.sv =====
// axis and multiplier selection and step count for one poll
`default_nettype none
module hjc_poll (
    input  wire hjc_pkg::t_in_item                       i_item,
    input  wire hjc_pkg::t_cfg                           i_cfg,
    input  wire logic [2:0]                              i_cur_axis,
    input  wire logic signed [hjc_pkg::DeltaWidth-1:0]   i_delta,
    output hjc_pkg::t_out_item                           o_result,
    output logic [2:0]                                   o_next_axis
);
    import hjc_pkg::*;

    logic [2:0]                  axis;
    logic [MultWidth-1:0]        mult;
    logic signed [DeltaWidth-1:0] taken;
    logic [DeltaWidth-1:0]       mag;
    logic                        allow;
    logic [DeltaWidth+MultWidth-1:0] prod;

    always_comb begin
        // priority pick, lowest line wins
        if (i_item.axis_lines[0]) begin
            axis = 3'd0;
        end else if (i_item.axis_lines[1]) begin
            axis = 3'd1;
        end else if (i_item.axis_lines[2]) begin
            axis = 3'd2;
        end else if (i_item.axis_lines[3]) begin
            axis = 3'd3;
        end else begin
            axis = AXIS_NONE;
        end

        if (i_item.mult_lines[0]) begin
            mult = i_cfg.mult_low;
        end else if (i_item.mult_lines[1]) begin
            mult = i_cfg.mult_mid;
        end else if (i_item.mult_lines[2]) begin
            mult = i_cfg.mult_high;
        end else begin
            mult = '0;
        end

        // an axis change throws away what was accumulated
        taken = (axis != i_cur_axis) ? '0 : i_delta;
        mag   = taken[DeltaWidth-1] ? DeltaWidth'(-taken) : DeltaWidth'(taken);
        allow = i_item.motion_idle && !i_item.halted && (axis != AXIS_NONE) &&
                ({1'b0, axis} < i_cfg.motor_cnt);
        prod  = (DeltaWidth+MultWidth)'(mag) * (DeltaWidth+MultWidth)'(mult);

        o_next_axis         = axis;
        o_result.axis_sel   = axis;
        o_result.pilot      = (axis != AXIS_NONE);
        o_result.mult_now   = mult;
        o_result.step_dir   = !taken[DeltaWidth-1] && (taken != '0);
        o_result.step_count = allow ? prod[CountWidth-1:0] : '0;
    end

endmodule
`default_nettype wire

// ===== sv/handwheel_jog_controller_unit.sv =====
// top level of the handwheel jog controller: handshakes, state and registers
//
// usage
// - input channel (i_in_valid / o_in_ready / i_in_data) carries samples and polls;
//   a sample (func 0) decodes the encoder pair and moves the jog delta, a poll
//   (func 1) selects axis and multiplier, takes the delta and yields one result
// - output channel (o_out_valid / i_out_ready / o_out_data) carries one result
//   per poll; samples produce nothing on it
// - configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   is always ready; indexes past the encoder-present register are dropped
// - a poll goes through the input register, then the result register, from which
//   its result leaves on the output channel
// - throughput: one item per cycle unless a poll waits on a full result register;
//   the 16x8 step-count multiply between the two registers sets the cycle time
// - reset (synchronous, active low) empties both registers, clears delta and
//   the previous encoder pair, selects no axis and loads register defaults
// - while a result waits for the receiver, samples keep flowing; a poll waits
//   in the input register until the result register frees up, and input ready
//   stays low meanwhile
`default_nettype none
module handwheel_jog_controller_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire hjc_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output hjc_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hjc_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  wire logic [hjc_pkg::MultWidth-1:0]  i_cfg_data
);
    import hjc_pkg::*;

`include "handwheel_jog_controller_unit_macros.svh"

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic     r_in_vld;
    t_in_item r_in;

    // jog state
    logic [1:0]                  r_prev_ab, n_prev_ab;
    logic signed [DeltaWidth-1:0] r_delta, n_delta;
    logic [2:0]                  r_cur_axis, n_cur_axis;

    // result register
    logic      r_out_vld;
    t_out_item r_out;

    logic                         adv;
    logic                         is_poll;
    logic [1:0]                   cur_ab;
    logic signed [DeltaWidth-1:0] quad_delta;
    t_out_item                    poll_result;
    logic [2:0]                   poll_axis;

    assign cur_ab  = {r_in.enc_b, r_in.enc_a};
    assign is_poll = (r_in.func == FUNC_POLL);

    // a held item moves on unless it is a poll with the result slot still full
    assign adv         = r_in_vld && (!is_poll || !r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    hjc_quad u_quad (
        .i_prev_ab (r_prev_ab),
        .i_ab      (cur_ab),
        .i_delta   (r_delta),
        .o_delta   (quad_delta)
    );

    hjc_poll u_poll (
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .i_cur_axis  (r_cur_axis),
        .i_delta     (r_delta),
        .o_result    (poll_result),
        .o_next_axis (poll_axis)
    );

    // next jog state for the item leaving the input register
    always_comb begin
        n_prev_ab  = r_prev_ab;
        n_delta    = r_delta;
        n_cur_axis = r_cur_axis;
        if (adv) begin
            if (is_poll) begin
                n_cur_axis = poll_axis;
                n_delta    = '0;
            end else if (r_cfg.enc_pres) begin
                // encoder absent leaves both delta and the old pair alone
                n_prev_ab = cur_ab;
                n_delta   = quad_delta;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mult_low  <= RST_MULT_LOW;
            r_cfg.mult_mid  <= RST_MULT_MID;
            r_cfg.mult_high <= RST_MULT_HIGH;
            r_cfg.motor_cnt <= RST_MOTOR_CNT;
            r_cfg.enc_pres  <= RST_ENC_PRES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MULT_LOW:  r_cfg.mult_low  <= i_cfg_data;
                REG_MULT_MID:  r_cfg.mult_mid  <= i_cfg_data;
                REG_MULT_HIGH: r_cfg.mult_high <= i_cfg_data;
                REG_MOTOR_CNT: r_cfg.motor_cnt <= i_cfg_data[3:0];
                REG_ENC_PRES:  r_cfg.enc_pres  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // jog state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab  <= '0;
            r_delta    <= '0;
            r_cur_axis <= AXIS_NONE;
        end else begin
            r_prev_ab  <= n_prev_ab;
            r_delta    <= n_delta;
            r_cur_axis <= n_cur_axis;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && is_poll) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (adv && is_poll) begin
            r_out <= poll_result;
        end
    end

    // lamp follows the reported axis
    `HJC_ASSERT_IMP(a_pilot_axis, i_clk, i_rst_n, r_out_vld,
        r_out.pilot == (r_out.axis_sel != AXIS_NONE))
    // steps only go out with a real axis and a nonzero multiplier
    `HJC_ASSERT_IMP(a_step_needs_mult, i_clk, i_rst_n, r_out_vld && (r_out.step_count != '0),
        r_out.pilot && (r_out.mult_now != '0))
    // a retired poll always leaves the delta empty
    `HJC_ASSERT_NEXT(a_poll_clears, i_clk, i_rst_n, adv && is_poll, r_delta == '0)
    // samples never move the selected axis
    `HJC_ASSERT_NEXT(a_sample_keeps_axis, i_clk, i_rst_n, adv && !is_poll,
        r_cur_axis == $past(r_cur_axis))

endmodule
`default_nettype wire

// ===== bench/handwheel_jog_controller_unit_tb.sv =====
// self-checking bench for the handwheel jog controller: directed and random samples and polls
module handwheel_jog_controller_unit_tb;
    import hjc_pkg::*;

    // overall cycle budget; the slowest legal run stays well below it
    localparam int CycleLimit = 500_000;
    // cycles to let the pipeline empty after the last expected result
    localparam int SettleCycles = 4;
    // register indexes past the last real register; writes there are dropped
    localparam logic [CfgIdxWidth-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CfgIdxWidth-1:0] REG_SPARE_HI = 3'd7;
    // delta per {previous ab, current ab} pair
    localparam int QUAD_MOVE [0:15] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
    localparam int DeltaMax = 32767;
    localparam int DeltaMin = -32768;
    // motor count written in each random phase
    localparam logic [7:0] MotorPick [6] = '{8'd8, 8'd0, 8'hF3, 8'd15, 8'd1, 8'd4};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [MultWidth-1:0] cfg_data = '0;

    // items waiting for the driver, and results the predictor says are due
    t_in_item jog_items_q[$];
    t_out_item jog_expect_q[$];

    // predictor state and its copy of the registers
    logic [1:0] enc_prev;
    int jog_delta;
    logic [2:0] sel_axis;
    t_cfg jog_cfg;

    // stimulus side bookkeeping
    bit no_idle = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_draw;
    logic [1:0] gen_ab = 2'd0;
    logic [3:0] last_axes = 4'b0001;
    int fail_count = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    handwheel_jog_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    task automatic jog_mismatch(input string msg);
        // keep the log short if the block is badly broken
        if (fail_count < 50) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        fail_count++;
    endtask

    // works out what one accepted item does to the jog state, queues any result
    task automatic jog_predict(input t_in_item it);
        logic [1:0] ab;
        int sum;
        logic [2:0] axis_next;
        logic [7:0] mult;
        int taken;
        logic [31:0] mag;
        logic [31:0] count;
        t_out_item res;
        if (it.func == FUNC_SAMPLE) begin
            // absent encoder: nothing moves, previous pair kept
            if (jog_cfg.enc_pres) begin
                ab = {it.enc_b, it.enc_a};
                sum = jog_delta + QUAD_MOVE[{enc_prev, ab}];
                if (sum > DeltaMax) sum = DeltaMax;
                if (sum < DeltaMin) sum = DeltaMin;
                jog_delta = sum;
                enc_prev = ab;
            end
        end else begin
            if (it.axis_lines[0]) axis_next = 3'd0;
            else if (it.axis_lines[1]) axis_next = 3'd1;
            else if (it.axis_lines[2]) axis_next = 3'd2;
            else if (it.axis_lines[3]) axis_next = 3'd3;
            else axis_next = AXIS_NONE;
            // switching axis throws away what was accumulated
            if (axis_next != sel_axis) begin
                sel_axis = axis_next;
                jog_delta = 0;
            end
            if (it.mult_lines[0]) mult = jog_cfg.mult_low;
            else if (it.mult_lines[1]) mult = jog_cfg.mult_mid;
            else if (it.mult_lines[2]) mult = jog_cfg.mult_high;
            else mult = '0;
            taken = jog_delta;
            jog_delta = 0;
            mag = (taken < 0) ? -taken : taken;
            count = '0;
            if (it.motion_idle && !it.halted && sel_axis != AXIS_NONE
                    && {1'b0, sel_axis} < jog_cfg.motor_cnt && mag != 0) begin
                count = mag * mult;
            end
            res.axis_sel = sel_axis;
            res.pilot = (sel_axis != AXIS_NONE);
            res.mult_now = mult;
            res.step_dir = (taken > 0);
            res.step_count = count[CountWidth-1:0];
            jog_expect_q.push_back(res);
        end
    endtask

    task automatic jog_compare(input t_out_item got);
        t_out_item want;
        if (jog_expect_q.size() == 0) begin
            jog_mismatch("result with no poll outstanding");
        end else begin
            want = jog_expect_q.pop_front();
            if (got.axis_sel !== want.axis_sel)
                jog_mismatch($sformatf("axis_sel %0d, want %0d", got.axis_sel, want.axis_sel));
            if (got.pilot !== want.pilot)
                jog_mismatch($sformatf("pilot %0d, want %0d", got.pilot, want.pilot));
            if (got.mult_now !== want.mult_now)
                jog_mismatch($sformatf("mult_now %0d, want %0d", got.mult_now, want.mult_now));
            if (got.step_dir !== want.step_dir)
                jog_mismatch($sformatf("step_dir %0d, want %0d", got.step_dir, want.step_dir));
            if (got.step_count !== want.step_count)
                jog_mismatch($sformatf("step_count %0d, want %0d",
                    got.step_count, want.step_count));
        end
    endtask

    // predictor follows every transfer on the input and register channels
    always @(posedge clk) begin
        if (!rst_n) begin
            enc_prev = 2'd0;
            jog_delta = 0;
            sel_axis = AXIS_NONE;
            jog_cfg = '{RST_MULT_LOW, RST_MULT_MID, RST_MULT_HIGH, RST_MOTOR_CNT, RST_ENC_PRES};
        end else begin
            if (in_valid && in_ready) begin
                jog_predict(in_data);
            end
            if (cfg_valid && cfg_ready) begin
                case (t_reg_idx'(cfg_index))
                    REG_MULT_LOW:  jog_cfg.mult_low = cfg_data;
                    REG_MULT_MID:  jog_cfg.mult_mid = cfg_data;
                    REG_MULT_HIGH: jog_cfg.mult_high = cfg_data;
                    REG_MOTOR_CNT: jog_cfg.motor_cnt = cfg_data[3:0];
                    REG_ENC_PRES:  jog_cfg.enc_pres = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // input driver: holds each item until its transfer, then a gap, random unless no_idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (in_valid && !in_ready) begin
            // hold item and payload until the block takes it
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (jog_items_q.size() != 0) begin
            in_data <= jog_items_q.pop_front();
            in_valid <= 1'b1;
            gap_left <= no_idle ? 0 : $urandom_range(0, 8);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result monitor: checks each transfer, stalls the next at random unless no_idle
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && out_ready) begin
            jog_compare(out_data);
            stall_draw = no_idle ? 0 : $urandom_range(0, 8);
            stall_left <= stall_draw;
            out_ready <= (stall_draw == 0);
        end else if (out_valid && stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end else begin
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [1:0] gray_next(input logic [1:0] ab, input bit up);
        case (ab)
            2'd0: return up ? 2'd2 : 2'd1;
            2'd1: return up ? 2'd0 : 2'd3;
            2'd2: return up ? 2'd3 : 2'd0;
            default: return up ? 2'd1 : 2'd2;
        endcase
    endfunction

    // encoder sample with the given pair; unused fields carry noise
    task automatic push_ab(input logic [1:0] ab);
        t_in_item it;
        it = t_in_item'($urandom);
        it.func = FUNC_SAMPLE;
        it.enc_a = ab[0];
        it.enc_b = ab[1];
        gen_ab = ab;
        jog_items_q.push_back(it);
    endtask

    task automatic push_walk(input bit up, input int n);
        for (int i = 0; i < n; i++) push_ab(gray_next(gen_ab, up));
    endtask

    task automatic push_poll(input logic [3:0] axes, input logic [2:0] mults,
                             input bit idle, input bit halt);
        t_in_item it;
        it = t_in_item'($urandom);
        it.func = FUNC_POLL;
        it.axis_lines = axes;
        it.mult_lines = mults;
        it.motion_idle = idle;
        it.halted = halt;
        jog_items_q.push_back(it);
    endtask

    // wait until all items are taken and every result is back, then let the pipe empty
    task automatic drain();
        while (jog_items_q.size() != 0 || in_valid || jog_expect_q.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx, input logic [MultWidth-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // mostly encoder runs ended by a poll, with some broken pairs and raw noise
    task automatic run_random(input int n);
        int added;
        int k;
        bit up;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, 12);
                up = 1'($urandom_range(0, 1));
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 15) == 0) push_ab(2'($urandom));
                    else push_ab(gray_next(gen_ab, up));
                end
                // usually stay on the same axis so the delta survives
                if ($urandom_range(0, 4) == 0) last_axes = 4'($urandom);
                push_poll(last_axes, 3'($urandom), $urandom_range(0, 5) != 0,
                          $urandom_range(0, 5) == 0);
                added += k + 1;
            end else begin
                jog_items_q.push_back(t_in_item'($urandom));
                added++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on reset register values
        push_poll(4'b0001, 3'b001, 1'b1, 1'b0);     // first axis pick clears delta
        push_walk(1'b1, 4);
        push_poll(4'b1111, 3'b111, 1'b1, 1'b0);     // both priority chains, steps forward
        push_walk(1'b0, 3);
        push_poll(4'b0001, 3'b110, 1'b1, 1'b1);     // halted
        push_ab(2'd0);
        push_ab(2'd1);
        push_poll(4'b0001, 3'b100, 1'b0, 1'b0);     // motion busy
        push_ab(2'd2);                              // illegal jump, no move
        push_ab(2'd3);
        push_poll(4'b0010, 3'b010, 1'b1, 1'b0);     // axis change drops delta
        push_ab(2'd1);
        push_poll(4'b0010, 3'b000, 1'b1, 1'b0);     // no multiplier line
        push_poll(4'b0000, 3'b001, 1'b1, 1'b0);     // no axis
        push_ab(2'd0);
        push_poll(4'b0000, 3'b001, 1'b1, 1'b0);     // no axis never steps
        push_poll(4'b1000, 3'b100, 1'b1, 1'b0);
        push_ab(2'd2);
        push_poll(4'b1000, 3'b100, 1'b1, 1'b0);     // fourth axis under motor count
        push_poll(4'b0100, 3'b001, 1'b1, 1'b0);
        drain();

        // writes past the last register must change nothing
        for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
            cfg_write(CfgIdxWidth'(i), 8'($urandom));
        // encoder absent: samples contribute nothing
        cfg_write(REG_ENC_PRES, 8'h02);
        push_walk(1'b1, 5);
        push_poll(4'b0100, 3'b001, 1'b1, 1'b0);
        drain();
        cfg_write(REG_ENC_PRES, 8'h01);

        // long runs in both directions at the largest multiplier
        cfg_write(REG_MULT_LOW, 8'hFF);
        no_idle = 1'b1;
        push_poll(4'b0001, 3'b001, 1'b1, 1'b0);
        push_walk(1'b1, 60);
        push_poll(4'b0001, 3'b001, 1'b1, 1'b0);
        push_walk(1'b0, 60);
        push_poll(4'b0001, 3'b001, 1'b1, 1'b0);
        drain();
        no_idle = 1'b0;

        // random phases across register settings, extremes first
        for (int p = 0; p < 6; p++) begin
            cfg_write(REG_MULT_LOW, (p == 0) ? 8'd0 : (p == 1) ? 8'hFF : 8'($urandom));
            cfg_write(REG_MULT_MID, (p == 0) ? 8'd0 : (p == 1) ? 8'hFF : 8'($urandom));
            cfg_write(REG_MULT_HIGH, (p == 0) ? 8'd0 : (p == 1) ? 8'hFF : 8'($urandom));
            cfg_write(REG_MOTOR_CNT, MotorPick[p]);
            cfg_write(REG_ENC_PRES, p[0] ? 8'hFF : 8'h01);
            if ($urandom_range(0, 1))
                cfg_write(CfgIdxWidth'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 8'hFF);
            // one phase runs back to back with no idling on either side
            no_idle = (p == 4);
            run_random(200);
            drain();
        end
        no_idle = 1'b0;

        if (jog_expect_q.size() != 0) begin
            jog_mismatch($sformatf("%0d results never arrived", jog_expect_q.size()));
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
